FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, switched off while in reset
`define ASSERT_CLK_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked at every rising edge, reset included
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/kmsp_pkg.sv
// ----------------------------------------------------------------------------
// kmsp_pkg
// types, codes and the host key table of the keyboard matrix scan port
// ----------------------------------------------------------------------------
package kmsp_pkg;

    typedef enum logic [1:0] {
        REQ_KEY   = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2
    } req_type_t;

    localparam logic PORT_A = 1'b0;
    localparam logic PORT_B = 1'b1;

    localparam logic [7:0] KEY_UP_CODE    = 8'h26;
    localparam logic [7:0] KEY_LEFT_CODE  = 8'h25;
    localparam logic [7:0] KEY_SEVEN_CODE = 8'h37;

    localparam logic [7:0] LATCH_RESET = 8'hFF;

    // bit {row, col} is the key at that row and column
    typedef logic [63:0] matrix_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] host_key;
        logic       key_down;
        logic       shift_held;
        logic       port_select;
        logic [7:0] write_value;
    } item_t;

    typedef struct packed {
        logic    apply;
        logic    down;
        matrix_t mask;
    } key_cmd_t;

    function automatic matrix_t key_bit(input logic [2:0] row, input logic [2:0] col);
        matrix_t m;
        m = '0;
        m[{row, col}] = 1'b1;
        return m;
    endfunction

    // host key code to matrix position, zero for unknown codes
    function automatic matrix_t key_lookup(input logic [7:0] code, input logic shift);
        matrix_t m;
        m = '0;
        case (code)
            KEY_UP_CODE:    m = key_bit(3'd1, 3'd7) | key_bit(3'd0, 3'd7);
            KEY_LEFT_CODE:  m = key_bit(3'd1, 3'd7) | key_bit(3'd0, 3'd2);
            KEY_SEVEN_CODE: m = shift ? key_bit(3'd6, 3'd7) : key_bit(3'd3, 3'd0);
            8'h13: m = key_bit(3'd7, 3'd7);
            8'hBC: m = key_bit(3'd5, 3'd7);
            8'h4E: m = key_bit(3'd4, 3'd7);
            8'h56: m = key_bit(3'd3, 3'd7);
            8'h58: m = key_bit(3'd2, 3'd7);
            8'hA0: m = key_bit(3'd1, 3'd7);
            8'h28: m = key_bit(3'd0, 3'd7);
            8'h51: m = key_bit(3'd7, 3'd6);
            8'hDC: m = key_bit(3'd6, 3'd6);
            8'h40: m = key_bit(3'd5, 3'd6);
            8'h4F: m = key_bit(3'd4, 3'd6);
            8'h55: m = key_bit(3'd3, 3'd6);
            8'h54: m = key_bit(3'd2, 3'd6);
            8'h45: m = key_bit(3'd1, 3'd6);
            8'h74: m = key_bit(3'd0, 3'd6);
            8'h5C: m = key_bit(3'd7, 3'd5);
            8'h5B: m = key_bit(3'd7, 3'd5);
            8'h3D: m = key_bit(3'd6, 3'd5);
            8'h3A: m = key_bit(3'd5, 3'd5);
            8'h4B: m = key_bit(3'd4, 3'd5);
            8'h48: m = key_bit(3'd3, 3'd5);
            8'h46: m = key_bit(3'd2, 3'd5);
            8'h53: m = key_bit(3'd1, 3'd5);
            8'h72: m = key_bit(3'd0, 3'd5);
            8'h20: m = key_bit(3'd7, 3'd4);
            8'hA1: m = key_bit(3'd6, 3'd4);
            8'hBE: m = key_bit(3'd5, 3'd4);
            8'h4D: m = key_bit(3'd4, 3'd4);
            8'h42: m = key_bit(3'd3, 3'd4);
            8'h43: m = key_bit(3'd2, 3'd4);
            8'h5A: m = key_bit(3'd1, 3'd4);
            8'h70: m = key_bit(3'd0, 3'd4);
            8'h32: m = key_bit(3'd7, 3'd3);
            8'h24: m = key_bit(3'd6, 3'd3);
            8'hBD: m = key_bit(3'd5, 3'd3);
            8'h30: m = key_bit(3'd4, 3'd3);
            8'h38: m = key_bit(3'd3, 3'd3);
            8'h36: m = key_bit(3'd2, 3'd3);
            8'h34: m = key_bit(3'd1, 3'd3);
            8'h76: m = key_bit(3'd0, 3'd3);
            8'h11: m = key_bit(3'd7, 3'd2);
            8'h3B: m = key_bit(3'd6, 3'd2);
            8'h4C: m = key_bit(3'd5, 3'd2);
            8'h4A: m = key_bit(3'd4, 3'd2);
            8'h47: m = key_bit(3'd3, 3'd2);
            8'h44: m = key_bit(3'd2, 3'd2);
            8'h41: m = key_bit(3'd1, 3'd2);
            8'h27: m = key_bit(3'd0, 3'd2);
            8'h2A: m = key_bit(3'd6, 3'd1);
            8'h50: m = key_bit(3'd5, 3'd1);
            8'h49: m = key_bit(3'd4, 3'd1);
            8'h59: m = key_bit(3'd3, 3'd1);
            8'h52: m = key_bit(3'd2, 3'd1);
            8'h57: m = key_bit(3'd1, 3'd1);
            8'h0D: m = key_bit(3'd0, 3'd1);
            8'h31: m = key_bit(3'd7, 3'd0);
            8'hBB: m = key_bit(3'd5, 3'd0);
            8'h39: m = key_bit(3'd4, 3'd0);
            8'h35: m = key_bit(3'd2, 3'd0);
            8'h33: m = key_bit(3'd1, 3'd0);
            8'h2E: m = key_bit(3'd0, 3'd0);
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/core/kmsp_keymap.sv
// ----------------------------------------------------------------------------
// kmsp_keymap
// turns a key event beat into a set or clear command on the matrix
// ----------------------------------------------------------------------------
module kmsp_keymap (
    input  kmsp_pkg::item_t    item,
    input  logic               fire,
    output kmsp_pkg::key_cmd_t cmd
);
    import kmsp_pkg::*;

    always_comb begin
        cmd.apply = fire && (item.req_type == REQ_KEY);
        cmd.down  = item.key_down;
        cmd.mask  = key_lookup(item.host_key, item.shift_held);
    end

endmodule

FILE: rtl/core/kmsp_state.sv
// ----------------------------------------------------------------------------
// kmsp_state
// key matrix and port latches, with the active-low port read logic
// ----------------------------------------------------------------------------
module kmsp_state (
    input  logic               aclk,
    input  logic               aresetn,
    input  kmsp_pkg::item_t    item,
    input  logic               fire,
    input  kmsp_pkg::key_cmd_t cmd,
    output logic [7:0]         read_value
);
    import kmsp_pkg::*;

    matrix_t    rows_reg, rows_next;
    logic [7:0] pa_reg, pa_next;
    logic [7:0] pb_reg, pb_next;
    logic [7:0] acc_a, acc_b;

    always_comb begin
        rows_next = rows_reg;
        pa_next   = pa_reg;
        pb_next   = pb_reg;
        if (cmd.apply) begin
            rows_next = cmd.down ? (rows_reg | cmd.mask) : (rows_reg & ~cmd.mask);
        end
        if (fire && item.req_type == REQ_WRITE) begin
            if (item.port_select == PORT_A) begin
                pa_next = item.write_value;
            end else begin
                pb_next = item.write_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= '0;
            pa_reg   <= LATCH_RESET;
            pb_reg   <= LATCH_RESET;
        end else begin
            rows_reg <= rows_next;
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
        end
    end

    always_comb begin
        acc_b = '0;
        for (int r = 0; r < 8; r++) begin
            acc_a[r] = |(rows_reg[r*8 +: 8] & ~pb_reg);
            if (!pa_reg[r]) begin
                acc_b = acc_b | rows_reg[r*8 +: 8];
            end
        end
        read_value = (item.port_select == PORT_A) ? ~acc_a : ~acc_b;
    end

endmodule

FILE: rtl/core/keyboard_matrix_scan_port.sv
// ----------------------------------------------------------------------------
// keyboard_matrix_scan_port
// 8x8 key matrix with two port latches, scanned through port reads
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one request beat (key event, port write or port read)
//   m_ channel: one read_value beat for each port read, none for other kinds
//   a beat is registered, then applied to the matrix and latches once it fires
//   from the input register; a read's byte enters the output register at that edge
//   throughput: one beat per cycle while no read is stalled, set by the single
//   input register feeding the state update and read logic
//   reset clears the matrix, sets both latches to 0xff and drops m_valid
//   while m_ready is low with a result waiting, key events and writes still
//   pass; a read holds in the input register and s_ready drops behind it
// ----------------------------------------------------------------------------
module keyboard_matrix_scan_port (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [7:0] s_host_key,
    input  logic       s_key_down,
    input  logic       s_shift_held,
    input  logic       s_port_select,
    input  logic [7:0] s_write_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_value
);
    import kmsp_pkg::*;

    item_t      item_reg;
    logic       in_valid_reg;
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       is_read;
    logic       fire;
    logic       out_free;
    key_cmd_t   cmd;
    logic [7:0] read_value;

    assign is_read  = item_reg.req_type == REQ_READ;
    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && (!is_read || out_free);
    assign s_ready  = !in_valid_reg || fire;

    kmsp_keymap u_keymap (
        .item (item_reg),
        .fire (fire),
        .cmd  (cmd)
    );

    kmsp_state u_state (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item       (item_reg),
        .fire       (fire),
        .cmd        (cmd),
        .read_value (read_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire && is_read) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= '{req_type: s_req_type, host_key: s_host_key,
                          key_down: s_key_down, shift_held: s_shift_held,
                          port_select: s_port_select, write_value: s_write_value};
        end
        if (fire && is_read) begin
            out_data_reg <= read_value;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_read_value = out_data_reg;

endmodule

FILE: rtl/core/kmsp_checker.sv
// ----------------------------------------------------------------------------
// kmsp_checker
// port level checks on the keyboard matrix scan port
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kmsp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_value
);

    // no result beat right after reset
    `ASSERT_CLK(a_reset_clears_out, aclk, !aresetn |=> !m_valid, "m_valid after reset")

    // a stalled result beat holds its byte
    `ASSERT_CLK_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_read_value), "result changed while stalled")

    // with the output register empty nothing can block the input side
    `ASSERT_CLK_RST(a_ready_when_empty, aclk, aresetn, !m_valid |-> s_ready, "s_ready low with empty output")

    // input only stalls behind a waiting result
    `ASSERT_CLK_RST(a_stall_cause, aclk, aresetn, s_valid && !s_ready |-> m_valid && !m_ready, "input stalled without output stall")

endmodule

bind keyboard_matrix_scan_port kmsp_checker u_kmsp_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_value (m_read_value)
);
